>>> rtl/core/integer_to_roman_numeral_core_macros.svh
// assertion macros for the integer to roman numeral core
`ifndef INTEGER_TO_ROMAN_NUMERAL_CORE_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITRN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ITRN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/itrn_pkg.sv
// shared types, constants and denomination tables for the roman numeral core
package itrn_pkg;

   localparam int ValueWidth  = 12;
   localparam int LetterWidth = 7;
   localparam int NumDenoms   = 13;
   localparam int DenomWidth  = $clog2(NumDenoms);

   localparam logic [ValueWidth-1:0] MaxValue = ValueWidth'(3999);

   localparam logic [LetterWidth-1:0] LetterNone = 7'h00;
   localparam logic [LetterWidth-1:0] LetterI    = 7'h49;
   localparam logic [LetterWidth-1:0] LetterV    = 7'h56;
   localparam logic [LetterWidth-1:0] LetterX    = 7'h58;
   localparam logic [LetterWidth-1:0] LetterL    = 7'h4C;
   localparam logic [LetterWidth-1:0] LetterC    = 7'h43;
   localparam logic [LetterWidth-1:0] LetterD    = 7'h44;
   localparam logic [LetterWidth-1:0] LetterM    = 7'h4D;

   localparam logic [ValueWidth-1:0] DenomValue [NumDenoms] = '{
      12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
      12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
   };

   localparam logic [LetterWidth-1:0] DenomFirst [NumDenoms] = '{
      LetterM, LetterC, LetterD, LetterC, LetterC, LetterX, LetterL,
      LetterX, LetterX, LetterI, LetterV, LetterI, LetterI
   };

   localparam logic [LetterWidth-1:0] DenomSecond [NumDenoms] = '{
      LetterNone, LetterM, LetterNone, LetterD, LetterNone, LetterC, LetterNone,
      LetterL, LetterNone, LetterX, LetterNone, LetterV, LetterNone
   };

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_word;
   } status_type;

endpackage

>>> rtl/core/itrn_datapath.sv
// remainder, pending letter and output word registers of the roman numeral core
module itrn_datapath (
   input  logic                                clock,
   input  itrn_pkg::cmd_type                   cmd,
   input  logic [itrn_pkg::ValueWidth-1:0]     req_value,
   output itrn_pkg::status_type                status,
   output logic [itrn_pkg::LetterWidth-1:0]    rsp_letter,
   output logic                                rsp_last,
   output logic                                rsp_invalid
);

   logic [itrn_pkg::ValueWidth-1:0]  rem_ff, rem_in;
   logic [itrn_pkg::LetterWidth-1:0] second_ff, second_in;
   logic                             bad_ff, bad_in;
   logic [itrn_pkg::LetterWidth-1:0] letter_ff, letter_in;
   logic                             last_ff, last_in;
   logic                             invalid_ff, invalid_in;
   logic [itrn_pkg::DenomWidth-1:0]  sel;
   logic [itrn_pkg::ValueWidth-1:0]  rem_sub;

   // largest denomination that fits the remainder
   always_comb begin
      sel = itrn_pkg::DenomWidth'(itrn_pkg::NumDenoms - 1);
      for (int i = itrn_pkg::NumDenoms - 1; i >= 0; i--) begin
         if (rem_ff >= itrn_pkg::DenomValue[i]) begin
            sel = itrn_pkg::DenomWidth'(i);
         end
      end
   end

   assign rem_sub = rem_ff - itrn_pkg::DenomValue[sel];

   always_comb begin
      rem_in     = rem_ff;
      second_in  = second_ff;
      bad_in     = bad_ff;
      letter_in  = letter_ff;
      last_in    = last_ff;
      invalid_in = invalid_ff;
      if (cmd.load) begin
         rem_in    = req_value;
         second_in = itrn_pkg::LetterNone;
         bad_in    = (req_value == '0) || (req_value > itrn_pkg::MaxValue);
      end else if (cmd.emit) begin
         priority if (bad_ff) begin
            letter_in  = itrn_pkg::LetterNone;
            last_in    = 1'b1;
            invalid_in = 1'b1;
         end else if (second_ff != itrn_pkg::LetterNone) begin
            letter_in  = second_ff;
            last_in    = (rem_ff == '0);
            invalid_in = 1'b0;
            second_in  = itrn_pkg::LetterNone;
         end else begin
            letter_in  = itrn_pkg::DenomFirst[sel];
            second_in  = itrn_pkg::DenomSecond[sel];
            rem_in     = rem_sub;
            last_in    = (rem_sub == '0) &&
                         (itrn_pkg::DenomSecond[sel] == itrn_pkg::LetterNone);
            invalid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      second_ff  <= second_in;
      bad_ff     <= bad_in;
      letter_ff  <= letter_in;
      last_ff    <= last_in;
      invalid_ff <= invalid_in;
   end

   assign status.last_word = last_in;
   assign rsp_letter       = letter_ff;
   assign rsp_last         = last_ff;
   assign rsp_invalid      = invalid_ff;

endmodule

>>> rtl/core/itrn_ctrl.sv
// handshake and sequencing state machine of the roman numeral core
`include "integer_to_roman_numeral_core_macros.svh"

module itrn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  itrn_pkg::status_type status,
   output itrn_pkg::cmd_type    cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cmd.load  = (state_ff == S_IDLE) && req_valid;
   assign cmd.emit  = (state_ff == S_RUN) && slot_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (status.last_word) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ITRN_ASSERT_NEXT(a_busy_after_load, cmd.load, req_stall, "no stall after load")
   `ITRN_ASSERT_NOW(a_one_command, 1'b1, !(cmd.load && cmd.emit), "load and emit together")
   `ITRN_ASSERT_NEXT(a_emit_shows_word, cmd.emit, rsp_valid, "emitted word not shown")

endmodule

>>> rtl/core/integer_to_roman_numeral_core.sv
// top level of the integer to roman numeral core
// usage:
//   req channel carries one 12-bit value per word; req_stall is high while a
//   value is being converted, so one value is taken at a time.
//   rsp channel carries one ascii letter per word (I V X L C D M), rsp_last on
//   the final letter. a value of 0 or above 3999 gives a single word with
//   rsp_letter 0, rsp_last 1 and rsp_invalid 1.
//   timing: the value taken is loaded into the remainder register, then the
//   letters are registered into the output register, one letter per cycle
//   while rsp_stall is low; a numeral has 1 to 15 letters, and the next value
//   is taken in the cycle after the last letter is registered.
//   rsp_stall holds the current word and pauses the conversion; req_stall
//   stays high until the last letter is in the output register.
//   reset clears the controller and drops rsp_valid; the block is then ready.
`include "integer_to_roman_numeral_core_macros.svh"

module integer_to_roman_numeral_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [itrn_pkg::ValueWidth-1:0]  req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [itrn_pkg::LetterWidth-1:0] rsp_letter,
   output logic                             rsp_last,
   output logic                             rsp_invalid
);

   itrn_pkg::cmd_type    cmd;
   itrn_pkg::status_type status;
   logic                 letter_known;

   itrn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itrn_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .req_value   (req_value),
      .status      (status),
      .rsp_letter  (rsp_letter),
      .rsp_last    (rsp_last),
      .rsp_invalid (rsp_invalid)
   );

   assign letter_known = (rsp_letter == itrn_pkg::LetterI) || (rsp_letter == itrn_pkg::LetterV) ||
                         (rsp_letter == itrn_pkg::LetterX) || (rsp_letter == itrn_pkg::LetterL) ||
                         (rsp_letter == itrn_pkg::LetterC) || (rsp_letter == itrn_pkg::LetterD) ||
                         (rsp_letter == itrn_pkg::LetterM);

   `ITRN_ASSERT_NOW(a_invalid_single, rsp_valid && rsp_invalid, rsp_last && (rsp_letter == itrn_pkg::LetterNone), "bad invalid word")
   `ITRN_ASSERT_NOW(a_letter_code, rsp_valid && !rsp_invalid, letter_known, "unknown letter")
   `ITRN_ASSERT_NEXT(a_hold_stalled, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_letter) && $stable(rsp_last) && $stable(rsp_invalid), "stalled word changed")

endmodule

>>> tb/integer_to_roman_numeral_core_tb.sv
// self-checking testbench for integer_to_roman_numeral_core with random idling and stalls
module integer_to_roman_numeral_core_tb;

   localparam int ValueWidth   = itrn_pkg::ValueWidth;
   localparam int LetterWidth  = itrn_pkg::LetterWidth;

   localparam int CycleLimit   = 500000;
   localparam int DrainCycles  = 40;
   localparam int ReportLimit  = 10;
   localparam int HighestValue = 3999;
   localparam int NumEdgeValues = 25;

   // range edges, all-ones, longest numeral, each subtractive pair
   localparam int EdgeValues [NumEdgeValues] = '{
      0, 1, HighestValue, HighestValue + 1, 4095, 3888, 4, 9, 40, 90,
      400, 900, 5, 50, 500, 1000, 10, 100, 14, 1994, 2048, 3000, 444,
      999, 1444
   };

   localparam logic [LetterWidth-1:0] RomanNone = '0;
   localparam logic [LetterWidth-1:0] RomanI    = LetterWidth'("I");
   localparam logic [LetterWidth-1:0] RomanV    = LetterWidth'("V");
   localparam logic [LetterWidth-1:0] RomanX    = LetterWidth'("X");
   localparam logic [LetterWidth-1:0] RomanL    = LetterWidth'("L");
   localparam logic [LetterWidth-1:0] RomanC    = LetterWidth'("C");
   localparam logic [LetterWidth-1:0] RomanD    = LetterWidth'("D");
   localparam logic [LetterWidth-1:0] RomanM    = LetterWidth'("M");

   typedef struct packed {
      logic [LetterWidth-1:0] letter;
      logic                   last;
      logic                   invalid;
   } numeral_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ValueWidth-1:0]  req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [LetterWidth-1:0] rsp_letter;
   logic                   rsp_last;
   logic                   rsp_invalid;

   logic [ValueWidth-1:0] pending_values [$];
   numeral_word_type      numeral_letters [$];
   numeral_word_type      wanted_word;
   int                    sender_idle_pct = 0;
   int                    receiver_stall_pct = 0;
   int                    values_queued = 0;
   int                    values_taken = 0;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   integer_to_roman_numeral_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_letter  (rsp_letter),
      .rsp_last    (rsp_last),
      .rsp_invalid (rsp_invalid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // spells the numeral digit by digit and appends its letters to the expected words
   function automatic void spell_roman(logic [ValueWidth-1:0] value);
      logic [LetterWidth-1:0] spelled [$];
      logic [LetterWidth-1:0] one, five, ten;
      int rest, digit;
      if (value == 0 || value > HighestValue) begin
         numeral_letters.push_back('{RomanNone, 1'b1, 1'b1});
         return;
      end
      rest = value;
      repeat (rest / 1000) spelled.push_back(RomanM);
      rest = rest % 1000;
      for (int place = 0; place < 3; place++) begin
         case (place)
            0: begin
               digit = rest / 100;
               one = RomanC; five = RomanD; ten = RomanM;
            end
            1: begin
               digit = (rest / 10) % 10;
               one = RomanX; five = RomanL; ten = RomanC;
            end
            default: begin
               digit = rest % 10;
               one = RomanI; five = RomanV; ten = RomanX;
            end
         endcase
         if (digit == 9) begin
            spelled.push_back(one);
            spelled.push_back(ten);
         end else if (digit == 4) begin
            spelled.push_back(one);
            spelled.push_back(five);
         end else begin
            if (digit >= 5) spelled.push_back(five);
            repeat (digit % 5) spelled.push_back(one);
         end
      end
      foreach (spelled[k])
         numeral_letters.push_back('{spelled[k], k == spelled.size() - 1, 1'b0});
   endfunction

   task automatic queue_value(int value);
      pending_values.push_back(ValueWidth'(value));
      values_queued++;
   endtask

   task automatic queue_random(int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 5) queue_value(0);
         else if (pick < 14) queue_value($urandom_range(4095, HighestValue + 1));
         else if (pick < 30) queue_value($urandom_range(60, 1));
         else queue_value($urandom_range(HighestValue, 1));
      end
   endtask

   // driver: holds a word until taken, then offers the next or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            spell_roman(req_value);
            values_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_value <= pending_values.pop_front();
            end else begin
               req_valid <= 1'b0;
               req_value <= ValueWidth'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // monitor: compares each taken word with the oldest expected letter
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (numeral_letters.size() == 0) begin
            if (mismatch_count < ReportLimit)
               $display("unexpected word: letter %h last %b invalid %b",
                        rsp_letter, rsp_last, rsp_invalid);
            mismatch_count++;
         end else begin
            wanted_word = numeral_letters.pop_front();
            if (rsp_letter !== wanted_word.letter || rsp_last !== wanted_word.last ||
                rsp_invalid !== wanted_word.invalid) begin
               if (mismatch_count < ReportLimit)
                  $display("mismatch: expected letter %h last %b invalid %b, got %h %b %b",
                           wanted_word.letter, wanted_word.last, wanted_word.invalid,
                           rsp_letter, rsp_last, rsp_invalid);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("integer_to_roman_numeral_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         if (phase == 0) begin
            foreach (EdgeValues[i])
               queue_value(EdgeValues[i]);
         end
         queue_random(phase == 0 ? 80 : 108);
         while (pending_values.size() != 0) @(posedge clock);
      end
      while (values_taken != values_queued || numeral_letters.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("integer_to_roman_numeral_core regression: pass");
      end else begin
         $display("integer_to_roman_numeral_core regression: fail");
      end
      $finish;
   end

endmodule
